FILE: rtl/rss_pkg.sv
package rss_pkg;

    // Fixed field widths
    localparam int REQ_TYPE_W = 2;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int PERM_LEN_W = 11;

    // Defaults
    localparam int MAX_LENGTH_DEF  = 1024;
    localparam int PERM_LEN_RST    = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_SHUFFLE = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ    = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_RESTART = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd2;

    // Work handed from front to back
    typedef enum logic [1:0] {
        OP_RESULT,   // result only, store untouched
        OP_READ,     // read entry at addr_a
        OP_SWAP,     // swap entries addr_a and addr_b
        OP_RESTART   // reload identity
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [STATUS_W-1:0]   status;
        logic                  done;
    } t_op_ctrl;

endpackage

FILE: rtl/rss_ifs.sv
interface rss_req_if import rss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [INDEX_W-1:0]    rand_index;
    logic [INDEX_W-1:0]    read_pos;

    modport source (output valid, output req_type, output rand_index, output read_pos,
                    input ready);
    modport sink   (input valid, input req_type, input rand_index, input read_pos,
                    output ready);
endinterface

interface rss_res_if import rss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                done_res;

    modport source (output valid, output value, output status, output done_res,
                    input ready);
    modport sink   (input valid, input value, input status, input done_res,
                    output ready);
endinterface

interface rss_cfg_if import rss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PERM_LEN_W-1:0] perm_length;

    modport source (output valid, output perm_length, input ready);
    modport sink   (input valid, input perm_length, output ready);
endinterface

FILE: rtl/rss_front.sv
module rss_front import rss_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int IDX_W      = $clog2(MAX_LENGTH),
    parameter int SP_W       = $clog2(MAX_LENGTH + 1),
    parameter int Q_W        = $bits(t_op_ctrl) + 2 * IDX_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rss_cfg_if.sink       i_cfg,
    rss_req_if.sink       i_req,
    input  logic          i_q_full,
    input  logic          i_clearing,
    output logic          o_q_push,
    output logic [Q_W-1:0] o_q_data
);

    localparam int CMP_W = (SP_W > PERM_LEN_W) ? SP_W : PERM_LEN_W;
    localparam logic [SP_W-1:0] LEN_RST =
        SP_W'((PERM_LEN_RST > MAX_LENGTH) ? MAX_LENGTH : PERM_LEN_RST);

    logic [SP_W-1:0]  r_len, n_len;
    logic [SP_W-1:0]  r_step, n_step;
    logic [CMP_W-1:0] cfg_ext, len_ext, step_ext, j_ext, rp_ext;
    logic             accept;
    logic             step_done;
    t_op_ctrl         op;
    logic [IDX_W-1:0] addr_a, addr_b;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !i_q_full && !i_clearing;
    assign accept      = i_req.valid && i_req.ready;

    // length clamp, settled at write time
    assign cfg_ext = CMP_W'(i_cfg.perm_length);
    always_comb begin
        priority if (cfg_ext == '0) begin
            n_len = SP_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_LENGTH)) begin
            n_len = SP_W'(MAX_LENGTH);
        end else begin
            n_len = SP_W'(cfg_ext);
        end
    end

    assign len_ext   = CMP_W'(r_len);
    assign step_ext  = CMP_W'(r_step);
    assign j_ext     = CMP_W'(i_req.rand_index);
    assign rp_ext    = CMP_W'(i_req.read_pos);
    assign step_done = step_ext >= len_ext;

    // classify
    always_comb begin
        op.kind   = OP_RESULT;
        op.status = ST_OK;
        op.done   = step_done;
        addr_a    = '0;
        addr_b    = '0;
        n_step    = r_step;
        unique case (i_req.req_type)
            REQ_SHUFFLE: begin
                if (step_done) begin
                    op.status = ST_DONE;
                end else if (j_ext >= len_ext) begin
                    op.status = ST_RANGE;
                end else begin
                    op.kind = OP_SWAP;
                    addr_a  = IDX_W'(r_step);
                    addr_b  = IDX_W'(i_req.rand_index);
                    n_step  = r_step + SP_W'(1);
                    op.done = (step_ext + CMP_W'(1)) >= len_ext;
                end
            end
            REQ_READ: begin
                if (rp_ext >= len_ext) begin
                    op.status = ST_RANGE;
                end else begin
                    op.kind = OP_READ;
                    addr_a  = IDX_W'(i_req.read_pos);
                end
            end
            REQ_RESTART: begin
                op.kind = OP_RESTART;
                op.done = 1'b0;
                n_step  = '0;
            end
            default: begin
                // unused code: plain result
            end
        endcase
    end

    assign o_q_push = accept;
    assign o_q_data = {op, addr_a, addr_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_RST;
            r_step <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_len <= n_len;
            end
            if (accept) begin
                r_step <= n_step;
            end
        end
    end

endmodule

FILE: rtl/rss_queue.sv
module rss_queue import rss_pkg::*; #(
    parameter int DATA_W = $bits(t_op_ctrl) + 2 * INDEX_W,
    parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_data  = r_slot[r_rd_ptr];
    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/rss_back.sv
module rss_back import rss_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int IDX_W      = $clog2(MAX_LENGTH),
    parameter int Q_W        = $bits(t_op_ctrl) + 2 * IDX_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  logic [Q_W-1:0] i_q_data,
    output logic           o_q_pop,
    output logic           o_clearing,
    rss_res_if.source      o_res
);

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_READ    = 5'b00100,
        S_SWAP_WI = 5'b01000,
        S_SWAP_WJ = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_clr_cnt, n_clr_cnt;
    logic [IDX_W-1:0]  r_store [MAX_LENGTH];
    logic [IDX_W-1:0]  r_rd_a, r_rd_b;
    logic [IDX_W-1:0]  r_addr_a, r_addr_b;
    t_op_ctrl          r_ctrl;

    t_op_ctrl          q_ctrl;
    logic [IDX_W-1:0]  q_addr_a, q_addr_b;
    logic              pop, out_free, load_out;
    logic              we;
    logic [IDX_W-1:0]  wa, wd;

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_done, n_done;

    assign {q_ctrl, q_addr_a, q_addr_b} = i_q_data;

    assign out_free   = !r_out_valid || o_res.ready;
    assign pop        = (r_state == S_IDLE) && !i_q_empty && out_free;
    assign o_q_pop    = pop;
    assign o_clearing = r_state == S_CLEAR;

    // result goes out at pop, except reads which wait for the store
    assign load_out = (pop && q_ctrl.kind != OP_READ) || (r_state == S_READ);

    always_comb begin
        if (r_state == S_READ) begin
            n_value  = VALUE_W'(r_rd_a);
            n_status = r_ctrl.status;
            n_done   = r_ctrl.done;
        end else begin
            n_value  = '0;
            n_status = q_ctrl.status;
            n_done   = q_ctrl.done;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + IDX_W'(1);
                if (r_clr_cnt == IDX_W'(MAX_LENGTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    unique case (q_ctrl.kind)
                        OP_RESULT:  n_state = S_IDLE;
                        OP_READ:    n_state = S_READ;
                        OP_SWAP:    n_state = S_SWAP_WI;
                        OP_RESTART: begin
                            n_state   = S_CLEAR;
                            n_clr_cnt = '0;
                        end
                    endcase
                end
            end
            S_READ:    n_state = S_IDLE;
            S_SWAP_WI: n_state = S_SWAP_WJ;
            S_SWAP_WJ: n_state = S_IDLE;
        endcase
    end

    // write port mux
    always_comb begin
        we = 1'b0;
        wa = r_clr_cnt;
        wd = r_clr_cnt;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
            end
            S_SWAP_WI: begin
                we = 1'b1;
                wa = r_addr_a;
                wd = r_rd_b;
            end
            S_SWAP_WJ: begin
                we = 1'b1;
                wa = r_addr_b;
                wd = r_rd_a;
            end
            S_IDLE, S_READ: begin
                we = 1'b0;
            end
        endcase
    end

    // store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[wa] <= wd;
        end
        if (pop) begin
            r_rd_a <= r_store[q_addr_a];
            r_rd_b <= r_store[q_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ctrl   <= q_ctrl;
            r_addr_a <= q_addr_a;
            r_addr_b <= q_addr_b;
        end
        if (load_out) begin
            r_value  <= n_value;
            r_status <= n_status;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.value    = r_value;
    assign o_res.status   = r_status;
    assign o_res.done_res = r_done;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !pop)
        else $error("queue popped outside idle");

    a_swap_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && q_ctrl.kind == OP_SWAP) |=> (r_state == S_SWAP_WI) ##1 (r_state == S_SWAP_WJ))
        else $error("swap did not write both entries");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || o_res.ready))
        else $error("pending word overwritten");

    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read result has no free slot");

    a_clear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_clr_cnt <= IDX_W'(MAX_LENGTH - 1)))
        else $error("clear counter past store end");

endmodule

FILE: rtl/random_swap_shuffle_unit.sv
// Swap shuffle: builds a random permutation of 0..L-1 in an on-chip store that
// starts as the identity, where L is perm_length clamped to 1..MAX_LENGTH.
// Each shuffle word swaps entry[step] with entry[rand_index] and advances step;
// once step reaches L further shuffles answer "complete" (status 2), and a
// rand_index >= L answers "range" (status 1) without touching anything. Read
// words return entry[read_pos] (status 1, value 0 when read_pos >= L). Restart
// reloads the identity and clears step. Every input word yields exactly one
// result word, in order. Structure: the front end classifies a word in its accept
// cycle and pushes it into a QUEUE_DEPTH-entry queue; the back end owns the
// store (one write port, two registered read ports). A swap reads both entries
// as it is popped, then writes each back in turn (S_SWAP_WI, S_SWAP_WJ); a read
// then waits in S_READ for the store. After reset and after each restart the back
// end writes all MAX_LENGTH identity entries, one entry per cycle, and input ready
// stays low while that pass runs; the restart's own result word is issued as
// the pass begins. Configuration writes are taken at any time (ready is tied
// high) and should only be issued while no word is in flight.
module random_swap_shuffle_unit import rss_pkg::*; #(
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rss_cfg_if.sink    i_cfg,
    rss_req_if.sink    i_req,
    rss_res_if.source  o_res
);

    // entry/address width and running-step width (step may equal MAX_LENGTH)
    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int SP_W  = $clog2(MAX_LENGTH + 1);
    localparam int Q_W   = $bits(t_op_ctrl) + 2 * IDX_W;

    logic           q_push, q_pop, q_full, q_empty;
    logic [Q_W-1:0] q_in, q_out;
    logic           clearing;

    // front: handshake, length clamp, range checks, running step
    rss_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .IDX_W      (IDX_W),
        .SP_W       (SP_W),
        .Q_W        (Q_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_req      (i_req),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    // decouples classification from store access
    rss_queue #(
        .DATA_W  (Q_W),
        .DEPTH   (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: store, swaps, reads, identity pass, result register
    rss_back #(
        .MAX_LENGTH (MAX_LENGTH),
        .IDX_W      (IDX_W),
        .Q_W        (Q_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_res      (o_res)
    );

endmodule
